// ----- design/cpc_pkg.sv -----
// cpc_pkg: shared widths, register indexes, limits and the coin value table
// for the coin pulse classifier. No dependencies.

package cpc_pkg;

	// fixed field and register widths
	localparam int REG_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int IDX_W     = 2;
	localparam int CNT_W     = 16;
	localparam int TOT_W     = 24;

	// default parameter values
	localparam int NUM_COINS_DEF   = 4;
	localparam int SAMPLE_BITS_DEF = 10;

	// number of signature registers in the register map
	localparam int SIG_SLOTS = 4;

	// detection margins and reset tolerance
	localparam int ARM_MARGIN = 3;
	localparam int END_MARGIN = 2;
	localparam int TOL_RESET  = 30;

	// saturation limits
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [TOT_W-1:0] TOT_MAX = '1;

	typedef logic [REG_W-1:0] reg_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASELINE  = 3'd0,
		REG_SIG0      = 3'd1,
		REG_SIG1      = 3'd2,
		REG_SIG2      = 3'd3,
		REG_SIG3      = 3'd4,
		REG_TOLERANCE = 3'd5
	} cfg_reg_t;

	// outcome of matching a peak against the signatures
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} match_t;

	// value of each coin in hundredths
	function automatic logic [TOT_W-1:0] coin_worth(input logic [IDX_W-1:0] idx);
		logic [TOT_W-1:0] w;
		case (idx)
			2'd0:    w = TOT_W'(5);
			2'd1:    w = TOT_W'(25);
			2'd2:    w = TOT_W'(50);
			default: w = TOT_W'(100);
		endcase
		return w;
	endfunction

endpackage

// ----- design/coin_pulse_classifier.sv -----
// coin_pulse_classifier: top level of the coin pulse classifier.
// Depends on cpc_pkg and cpc_match.
//
// Usage:
//   Input channel (in_valid/in_ready, sample) carries one sensor reading per
//   item. The running peak is tracked; a reading more than 3 above the
//   baseline arms detection and a later reading less than 2 off the baseline
//   ends the coin. The peak is then matched against the signatures and one
//   result item leaves on the output channel (out_valid/out_ready); readings
//   that do not end a coin give no result.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 baseline,
//   1..4 signatures, 5 tolerance); writes to other indexes are dropped.
//   Throughput: one item per cycle while no coin-ending item waits on a full
//   output register. An item is taken into the input register, then matched
//   and accounted, and its result is written into the output register.
//   Stall: the output register holds a result until taken. While it is full
//   and not being taken, items that end no coin still flow; an item that ends
//   a coin waits in the input register, and in_ready drops behind it.
//   Reset: peak, arming, counts and total clear, signatures and baseline go
//   to 0, tolerance to 30, and both channels come up empty.

module coin_pulse_classifier #(
	parameter int NUM_COINS   = cpc_pkg::NUM_COINS_DEF,
	parameter int SAMPLE_BITS = cpc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpc_pkg::REG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          recognized,
	output logic [cpc_pkg::IDX_W-1:0]     coin_index,
	output logic [cpc_pkg::REG_W-1:0]     peak_level,
	output logic [cpc_pkg::CNT_W-1:0]     coin_count,
	output logic [cpc_pkg::TOT_W-1:0]     total_value
);
	import cpc_pkg::*;

	localparam int NCOIN = (NUM_COINS > SIG_SLOTS) ? SIG_SLOTS : NUM_COINS;
	localparam int CW    = ((SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W) + 1;

	// configuration registers
	reg_t base_q;
	reg_t tol_q;
	reg_t sig_q [NCOIN];

	// input stage
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// pulse and accounting state
	logic [SAMPLE_BITS-1:0] peak_q;
	logic                   armed_q;
	logic [CNT_W-1:0]       cnt_q [NCOIN];
	logic [TOT_W-1:0]       total_q;

	// output register
	logic             out_valid_q;
	logic             recog_q;
	logic [IDX_W-1:0] idx_q;
	logic [REG_W-1:0] peak_out_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic [TOT_W-1:0] total_out_q;

	logic                   out_free;
	logic                   advance;
	logic                   ends;
	logic                   armed_new;
	logic [SAMPLE_BITS-1:0] peak_new;
	match_t                 mres;
	logic [CNT_W-1:0]       cnt_sel;
	logic [CNT_W-1:0]       cnt_inc;
	logic [TOT_W-1:0]       total_sat;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			tol_q  <= REG_W'(TOL_RESET);
			for (int i = 0; i < NCOIN; i++) begin
				sig_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_BASELINE) begin
				base_q <= cfg_data;
			end
			if (cfg_index == REG_TOLERANCE) begin
				tol_q <= cfg_data;
			end
			for (int i = 0; i < NCOIN; i++) begin
				if (cfg_index == CFG_IDX_W'(int'(REG_SIG0) + i)) begin
					sig_q[i] <= cfg_data;
				end
			end
		end
	end

	// handshake
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!ends || out_free);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
		end
	end

	// peak tracking, arming and end of pulse
	always_comb begin
		logic [CW-1:0] s_ext;
		logic [CW-1:0] b_ext;
		logic [CW-1:0] d;
		s_ext     = CW'(sample_s1);
		b_ext     = CW'(base_q);
		d         = (s_ext > b_ext) ? (s_ext - b_ext) : (b_ext - s_ext);
		peak_new  = (sample_s1 > peak_q) ? sample_s1 : peak_q;
		armed_new = armed_q || (s_ext > b_ext + CW'(ARM_MARGIN));
		ends      = armed_new && (d < CW'(END_MARGIN));
	end

	cpc_match #(
		.NCOIN       (NCOIN),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_match (
		.peak (peak_new),
		.sig  (sig_q),
		.tol  (tol_q),
		.res  (mres)
	);

	// count and total update
	always_comb begin
		logic [TOT_W:0] sum;
		cnt_sel = '0;
		for (int i = 0; i < NCOIN; i++) begin
			if (mres.idx == IDX_W'(i)) begin
				cnt_sel = cnt_q[i];
			end
		end
		cnt_inc   = (cnt_sel == CNT_MAX) ? cnt_sel : cnt_sel + CNT_W'(1);
		sum       = {1'b0, total_q} + {1'b0, coin_worth(mres.idx)};
		total_sat = sum[TOT_W] ? TOT_MAX : sum[TOT_W-1:0];
	end

	// pulse and accounting state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			armed_q <= 1'b0;
			total_q <= '0;
			for (int i = 0; i < NCOIN; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (advance) begin
			peak_q  <= ends ? '0 : peak_new;
			armed_q <= ends ? 1'b0 : armed_new;
			if (ends && mres.hit) begin
				total_q <= total_sat;
				for (int i = 0; i < NCOIN; i++) begin
					if (mres.idx == IDX_W'(i)) begin
						cnt_q[i] <= cnt_inc;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ends) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ends) begin
			recog_q     <= mres.hit;
			idx_q       <= mres.hit ? mres.idx : '0;
			peak_out_q  <= REG_W'(peak_new);
			cnt_out_q   <= mres.hit ? cnt_inc : '0;
			total_out_q <= mres.hit ? total_sat : total_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign recognized  = recog_q;
	assign coin_index  = idx_q;
	assign peak_level  = peak_out_q;
	assign coin_count  = cnt_out_q;
	assign total_value = total_out_q;

endmodule

// ----- design/cpc_match.sv -----
// cpc_match: compares a pulse peak against the coin signatures and picks
// the lowest matching index. Depends on cpc_pkg.

module cpc_match #(
	parameter int NCOIN       = cpc_pkg::NUM_COINS_DEF,
	parameter int SAMPLE_BITS = cpc_pkg::SAMPLE_BITS_DEF
) (
	input  logic [SAMPLE_BITS-1:0] peak,
	input  cpc_pkg::reg_t          sig [NCOIN],
	input  cpc_pkg::reg_t          tol,
	output cpc_pkg::match_t        res
);
	import cpc_pkg::*;

	localparam int CW = ((SAMPLE_BITS > REG_W) ? SAMPLE_BITS : REG_W) + 1;

	logic [NCOIN-1:0] close;

	// per-signature distance check
	always_comb begin
		logic [CW-1:0] p;
		logic [CW-1:0] s;
		logic [CW-1:0] d;
		p = CW'(peak);
		for (int i = 0; i < NCOIN; i++) begin
			s = CW'(sig[i]);
			d = (p > s) ? (p - s) : (s - p);
			close[i] = (d < CW'(tol));
		end
	end

	// lowest index wins
	always_comb begin
		res.hit = 1'b0;
		res.idx = '0;
		for (int i = NCOIN - 1; i >= 0; i--) begin
			if (close[i]) begin
				res.hit = 1'b1;
				res.idx = IDX_W'(i);
			end
		end
	end

endmodule

// ----- design/cpc_check.sv -----
// cpc_check: port-level assertions for the coin pulse classifier, bound to
// the top level. Depends on cpc_pkg and coin_pulse_classifier.

module cpc_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          recognized,
	input logic [cpc_pkg::IDX_W-1:0]     coin_index,
	input logic [cpc_pkg::REG_W-1:0]     peak_level,
	input logic [cpc_pkg::CNT_W-1:0]     coin_count,
	input logic [cpc_pkg::TOT_W-1:0]     total_value
);
	import cpc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(recognized) &&
		$stable(coin_index) && $stable(peak_level) && $stable(coin_count) &&
		$stable(total_value))
		else $error("result changed while stalled");

	// a rejected coin reports no index and no count
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !recognized |-> coin_index == '0 && coin_count == '0)
		else $error("rejected coin with index or count");

	// a recognized coin has been counted and added to the total
	a_hit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && recognized |-> coin_count != '0 && total_value != '0)
		else $error("recognized coin with zero count or total");

	// no result while in reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result present during reset");

endmodule

bind coin_pulse_classifier cpc_check u_cpc_check (.*);
